[rtl/sol_pkg.sv]
package sol_pkg;

  localparam int CAPACITY     = 16;
  localparam int KEY_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [1:0] MODE_LEAVE      = 2'd0;
  localparam logic [1:0] MODE_MOVE_FRONT = 2'd1;
  localparam logic [1:0] MODE_TRANSPOSE  = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // Operation broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic       lookup_go;
    logic       insert_go;
    logic [1:0] mode;
    entry_t     entry;
  } op_t;

endpackage

[rtl/self_organizing_list_lookup.sv]
// Self-organizing list lookup with move-to-front and transpose reordering.
// The input channel carries one operation per transaction: an insert that
// appends key and payload at the tail, or a lookup that searches from the
// head. Every accepted transaction yields exactly one result transaction
// with a status and, on a lookup hit, the stored payload.
// The list lives in a row of cells, one entry each. Cells compare their key
// in parallel and pass a "match seen" flag and their entry down the row, so
// the search and the reordering shift finish together in the execute cycle.
// An accepted item waits in the operation register for its execute cycle,
// during which the input is stalled; its result then goes to the output
// register. No new item is taken until the operation register is empty.
// The result sits in an output register; while the receiver stalls it, the
// block still accepts one more item but does not execute it until the
// result has been taken.
// Reset clears the entry count and the handshake state; entry contents are
// not cleared, since only entries below the count are ever read.
module self_organizing_list_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] entry_data_i,
  input  logic [1:0]  reorder_mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] found_data_o
);
  import sol_pkg::*;

  logic             op_valid_q;
  logic             func_q;
  logic [1:0]       mode_q;
  entry_t           op_entry_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [31:0]      found_q, found_d;

  logic   in_accept, exec, full;
  op_t    op;
  entry_t cell_entry [CAPACITY];
  logic   seen   [CAPACITY+1];
  logic   first  [CAPACITY+1];
  entry_t hit_entry;
  logic   hit_any;

  assign in_stall_o = op_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign exec       = op_valid_q && (!out_valid_q || !out_stall_i);
  assign full       = count_q == CNT_W'(CAPACITY);

  assign op.lookup_go = exec && (func_q == FUNC_LOOKUP);
  assign op.insert_go = exec && (func_q == FUNC_INSERT) && !full;
  assign op.mode      = mode_q;
  assign op.entry     = op_entry_q;

  assign seen[0]         = 1'b0;
  assign first[CAPACITY] = 1'b0;
  assign hit_any         = seen[CAPACITY];

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    sol_cell u_cell (
      .clk_i        (clk_i),
      .head_i       (j == 0),
      .valid_i      (CNT_W'(j) < count_q),
      .wr_sel_i     (count_q == CNT_W'(j)),
      .op_i         (op),
      .prev_i       (cell_entry[(j == 0) ? 0 : j-1]),
      .hit_entry_i  (hit_entry),
      .hit_any_i    (hit_any),
      .seen_i       (seen[j]),
      .next_first_i (first[j+1]),
      .seen_o       (seen[j+1]),
      .first_o      (first[j]),
      .entry_o      (cell_entry[j])
    );
  end

  // Only one cell flags the first match, so an OR over the row selects it.
  always_comb begin
    hit_entry = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (first[j]) begin
        hit_entry = hit_entry | cell_entry[j];
      end
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    found_d  = found_q;
    if (exec) begin
      found_d = '0;
      if (func_q == FUNC_INSERT) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          count_d  = count_q + CNT_W'(1);
        end
      end else if (hit_any) begin
        status_d = ST_OK;
        found_d  = 32'(hit_entry.payload);
      end else begin
        status_d = ST_MISS;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      count_q <= count_d;
      if (in_accept) begin
        op_valid_q <= 1'b1;
      end else if (exec) begin
        op_valid_q <= 1'b0;
      end
      if (exec) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q             <= func_i;
      mode_q             <= reorder_mode_i;
      op_entry_q.key     <= KEY_BITS'(key_i);
      op_entry_q.payload <= PAYLOAD_BITS'(entry_data_i);
    end
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign found_data_o = found_q;

endmodule

[rtl/sol_cell.sv]
module sol_cell (
  input  logic            clk_i,
  input  logic            head_i,
  input  logic            valid_i,
  input  logic            wr_sel_i,
  input  sol_pkg::op_t    op_i,
  input  sol_pkg::entry_t prev_i,
  input  sol_pkg::entry_t hit_entry_i,
  input  logic            hit_any_i,
  input  logic            seen_i,
  input  logic            next_first_i,
  output logic            seen_o,
  output logic            first_o,
  output sol_pkg::entry_t entry_o
);
  import sol_pkg::*;

  entry_t entry_q, entry_d;
  logic   match;
  logic   move_front, transpose;

  assign match      = valid_i && op_i.lookup_go && (entry_q.key == op_i.entry.key);
  assign first_o    = match && !seen_i;
  assign seen_o     = seen_i || match;
  assign move_front = op_i.mode == MODE_MOVE_FRONT;
  assign transpose  = op_i.mode == MODE_TRANSPOSE;
  assign entry_o    = entry_q;

  // A cell with no match ahead of it lies at or before the hit, so under
  // move to front it takes its predecessor's entry and the head takes the hit.
  always_comb begin
    entry_d = entry_q;
    priority if (op_i.insert_go && wr_sel_i) begin
      entry_d = op_i.entry;
    end else if (op_i.lookup_go && hit_any_i && move_front && !seen_i) begin
      entry_d = head_i ? hit_entry_i : prev_i;
    end else if (op_i.lookup_go && transpose && first_o && !head_i) begin
      entry_d = prev_i;
    end else if (op_i.lookup_go && transpose && next_first_i) begin
      entry_d = hit_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[rtl/sol_checker.sv]
module sol_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [31:0] found_data_o
);
  import sol_pkg::*;

  // A held result must not change under the receiver's stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(found_data_o))
    else $error("stalled result changed");

  // The operation register is occupied right after an accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled during execute cycle");

  // Only a lookup hit carries a payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> found_data_o == '0)
    else $error("payload on a miss or insert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_MISS) || (status_o == ST_FULL))
    else $error("undefined status code");

endmodule

bind self_organizing_list_lookup sol_checker u_sol_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .found_data_o (found_data_o)
);
